// ===== rtl/ncm_pkg.sv =====
// Package for the n-body collision merge unit: constants and sequencer state type.
package ncm_pkg;

  localparam int unsigned MaxBodiesDefault = 64;
  localparam logic [31:0] MergeDistReset   = 32'h0001_0000;
  localparam logic [47:0] MassMax          = 48'hFFFF_FFFF_FFFF;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegMergeDist = 2'd0;

  typedef enum logic [3:0] {
    StLoad,
    StCheckJ,
    StRdK,
    StWaitK,
    StDiff,
    StSquare,
    StAccum,
    StCompare,
    StMerge,
    StCount,
    StEmitRd,
    StEmitWait,
    StEmit
  } state_e;

endpackage

// ===== rtl/ncm_sq_unit.sv =====
// Shared squaring unit: one registered 33x33 multiply per cycle.
module ncm_sq_unit (
  input  logic        clk_i,
  input  logic [32:0] a_i,
  output logic [65:0] sq_o
);

  logic [65:0] sq_q;

  // Product register after the multiplier.
  always_ff @(posedge clk_i) begin
    sq_q <= 66'(a_i) * 66'(a_i);
  end

  assign sq_o = sq_q;

endmodule

// ===== rtl/nbody_collision_merge_unit.sv =====
// Top level of the n-body collision merge unit: body store, sequencer and APB port.
// Load: one body per transfer; stall stays low while loading.
// Merge: for each live body j, each later live pair (j,k) takes three squares through one
// shared multiplier, then accumulate, compare and merge.
// Emit: survivors are counted first, then each survivor is read and offered; removed bodies are skipped.
// Reset (rst_ni low, asynchronous) clears control, flags and count; merge_distance is 1.0.
module nbody_collision_merge_unit #(
  parameter int unsigned MAX_BODIES = ncm_pkg::MaxBodiesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [47:0] mass_i,
  input  logic        last_object_i,
  // Output channel.
  output logic        valid_o,
  input  logic        stall_i,
  output logic [5:0]  body_index_o,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_pos_z_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic signed [31:0] out_vel_z_o,
  output logic [47:0] out_mass_o,
  output logic [6:0]  survivor_count_o,
  output logic        last_result_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_BODIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BODIES);

  // Body memory, one word per body; read data registered.
  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [31:0] vx, vy, vz;
    logic [47:0] m;
  } body_t;

  body_t mem [MAX_BODIES];
  body_t rd_q;

  ncm_pkg::state_e state_q, state_d;

  logic [MAX_BODIES-1:0] alive_q;
  logic [CntW-1:0] n_q;
  logic [IdxW-1:0] j_q;
  logic [CntW-1:0] k_q;
  logic [CntW-1:0] surv_q, emitted_q;
  logic [1:0]  comp_q;
  logic [31:0] mdist_q;
  body_t       bj_q, bk_q;
  logic [32:0] diff_q;
  logic [65:0] sq;
  logic [67:0] acc_q;
  logic [63:0] limit_q;
  logic        close_q;
  logic [2:0]  step_q;
  logic [IdxW-1:0] rd_addr;
  logic        wr_en;
  logic [IdxW-1:0] wr_addr;
  body_t       wr_data;
  logic        in_xfer, out_xfer;

  assign in_xfer  = valid_i && !stall_o;
  assign out_xfer = valid_o && !stall_i;

  // APB register: always ready, index 0 only.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(ncm_pkg::RegMergeDist << 2)) ? mdist_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mdist_q <= ncm_pkg::MergeDistReset;
    end else if (psel && penable && pwrite && (paddr == 2'(ncm_pkg::RegMergeDist << 2))) begin
      mdist_q <= pwdata;
    end
  end

  // Shared squaring unit; also forms merge_distance squared at the start of each body j check.
  logic [32:0] sq_in;
  ncm_sq_unit u_sq (.clk_i(clk_i), .a_i(sq_in), .sq_o(sq));

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? 33'(a - b) : 33'(b - a);
  endfunction

  // Pick the squarer input: merge_distance in StCheckJ, else the current coordinate difference.
  always_comb begin
    case (comp_q)
      2'd0:    sq_in = (state_q == ncm_pkg::StCheckJ) ? {1'b0, mdist_q} : diff_q;
      default: sq_in = diff_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ncm_pkg::StLoad:     if (in_xfer && last_object_i) state_d = ncm_pkg::StCheckJ;
      ncm_pkg::StCheckJ: begin
        if (step_q == 3'd2) begin
          if (CntW'(j_q) + 1'b1 >= n_q) state_d = ncm_pkg::StCount;
          else if (alive_q[j_q]) state_d = ncm_pkg::StRdK;
        end
      end
      ncm_pkg::StRdK: begin
        if (k_q >= n_q) state_d = ncm_pkg::StCheckJ;
        else if (alive_q[IdxW'(k_q)]) state_d = ncm_pkg::StWaitK;
      end
      ncm_pkg::StWaitK:    state_d = ncm_pkg::StDiff;
      ncm_pkg::StDiff:     state_d = ncm_pkg::StSquare;
      ncm_pkg::StSquare:   state_d = ncm_pkg::StAccum;
      ncm_pkg::StAccum:    state_d = (comp_q == 2'd2) ? ncm_pkg::StCompare : ncm_pkg::StDiff;
      ncm_pkg::StCompare:  state_d = ncm_pkg::StMerge;
      ncm_pkg::StMerge:    state_d = ncm_pkg::StRdK;
      ncm_pkg::StCount:    if (CntW'(j_q) + 1'b1 >= n_q) state_d = ncm_pkg::StEmitRd;
      ncm_pkg::StEmitRd: begin
        if (k_q >= n_q) state_d = ncm_pkg::StLoad;
        else if (alive_q[IdxW'(k_q)]) state_d = ncm_pkg::StEmitWait;
      end
      ncm_pkg::StEmitWait: state_d = ncm_pkg::StEmit;
      ncm_pkg::StEmit:     if (out_xfer) state_d = ncm_pkg::StEmitRd;
      default:             state_d = ncm_pkg::StLoad;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    stall_o = (state_q != ncm_pkg::StLoad);
    valid_o = (state_q == ncm_pkg::StEmit);
    rd_addr = IdxW'(k_q);
    if (state_q == ncm_pkg::StCheckJ) rd_addr = j_q;
    wr_en   = 1'b0;
    wr_addr = IdxW'(n_q);
    wr_data = '{px: pos_x_i, py: pos_y_i, pz: pos_z_i,
                vx: vel_x_i, vy: vel_y_i, vz: vel_z_i, m: mass_i};
    if (state_q == ncm_pkg::StLoad) begin
      wr_en = in_xfer && (n_q < MaxCnt);
    end else if (state_q == ncm_pkg::StMerge && close_q) begin
      wr_en = 1'b1;
      wr_addr = j_q;
      wr_data = bj_q;
      wr_data.m  = ((49'(bj_q.m) + 49'(bk_q.m)) > 49'(ncm_pkg::MassMax)) ?
                   ncm_pkg::MassMax : bj_q.m + bk_q.m;
      wr_data.vx = sat_add(bj_q.vx, bk_q.vx);
      wr_data.vy = sat_add(bj_q.vy, bk_q.vy);
      wr_data.vz = sat_add(bj_q.vz, bk_q.vz);
    end
  end

  // Body memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ncm_pkg::StLoad;
      alive_q   <= '0;
      n_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      comp_q    <= '0;
      step_q    <= '0;
      surv_q    <= '0;
      emitted_q <= '0;
      acc_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ncm_pkg::StLoad: begin
          if (wr_en) begin
            alive_q[IdxW'(n_q)] <= 1'b1;
            n_q <= n_q + 1'b1;
          end
          j_q <= '0;
          step_q <= '0;
          comp_q <= '0;
        end
        ncm_pkg::StCheckJ: begin
          // Step 0 issues the read of j and the limit square, step 2 decides.
          step_q <= step_q + 1'b1;
          if (step_q == 3'd2) begin
            step_q <= '0;
            k_q <= CntW'(j_q) + 1'b1;
            if (!alive_q[j_q] && CntW'(j_q) + 1'b1 < n_q) j_q <= j_q + 1'b1;
            if (CntW'(j_q) + 1'b1 >= n_q) begin
              j_q <= '0;
              surv_q <= '0;
            end
          end
        end
        ncm_pkg::StRdK: begin
          if (k_q >= n_q) j_q <= j_q + 1'b1;
          else if (!alive_q[IdxW'(k_q)]) k_q <= k_q + 1'b1;
          comp_q <= '0;
          acc_q <= '0;
        end
        ncm_pkg::StAccum: begin
          acc_q  <= acc_q + 68'(sq);
          comp_q <= comp_q + 1'b1;
        end
        ncm_pkg::StMerge: begin
          if (close_q) alive_q[IdxW'(k_q)] <= 1'b0;
          k_q <= k_q + 1'b1;
        end
        ncm_pkg::StCount: begin
          surv_q <= surv_q + CntW'(alive_q[j_q]);
          j_q <= j_q + 1'b1;
          k_q <= '0;
          emitted_q <= '0;
        end
        ncm_pkg::StEmitRd: begin
          if (k_q >= n_q) begin
            alive_q <= '0;
            n_q <= '0;
          end else if (!alive_q[IdxW'(k_q)]) k_q <= k_q + 1'b1;
        end
        ncm_pkg::StEmit: begin
          if (out_xfer) begin
            k_q <= k_q + 1'b1;
            emitted_q <= emitted_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ncm_pkg::StCheckJ && step_q == 3'd1) limit_q <= sq[63:0];
    if (state_q == ncm_pkg::StCheckJ && step_q == 3'd2) bj_q <= rd_q;
    if (state_q == ncm_pkg::StMerge && close_q) bj_q <= wr_data;
    if (state_q == ncm_pkg::StDiff) begin
      case (comp_q)
        2'd0:    diff_q <= absdiff(bj_q.px, bk_q.px);
        2'd1:    diff_q <= absdiff(bj_q.py, bk_q.py);
        default: diff_q <= absdiff(bj_q.pz, bk_q.pz);
      endcase
    end
    if (state_q == ncm_pkg::StWaitK || state_q == ncm_pkg::StEmitWait) bk_q <= rd_q;
    if (state_q == ncm_pkg::StCompare) close_q <= (acc_q < 68'(limit_q));
  end

  // Result fields.
  assign body_index_o     = 6'(k_q);
  assign out_pos_x_o      = bk_q.px;
  assign out_pos_y_o      = bk_q.py;
  assign out_pos_z_o      = bk_q.pz;
  assign out_vel_x_o      = bk_q.vx;
  assign out_vel_y_o      = bk_q.vy;
  assign out_vel_z_o      = bk_q.vz;
  assign out_mass_o       = bk_q.m;
  assign survivor_count_o = 7'(surv_q);
  assign last_result_o    = (emitted_q + 1'b1 == surv_q);

endmodule

// ===== rtl/ncm_checker.sv =====
// Port-level checker for the n-body collision merge unit, with its bind.
module ncm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [6:0]  survivor_count_o,
  input logic        last_result_o
);

  // A result is never offered while input transfers are being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> stall_o)
    else $error("result offered while accepting input");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result dropped under stall");

  // The survivor count holds across a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(survivor_count_o))
    else $error("survivor count changed under stall");

  // Every offered result has a nonzero survivor count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> survivor_count_o != 7'd0)
    else $error("zero survivor count on a result");

  // The final-survivor mark holds across a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(last_result_o))
    else $error("last result mark changed under stall");

endmodule

bind nbody_collision_merge_unit ncm_checker u_ncm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .survivor_count_o(survivor_count_o),
  .last_result_o(last_result_o)
);

// ===== bench/tb_nbody_collision_merge_unit.sv =====
// Testbench for the n-body collision merge unit: predictor scoreboard, drivers and checks.
`timescale 1ns / 100ps

module tb_nbody_collision_merge_unit;

  localparam int unsigned BodyLimit = 64;
  localparam int unsigned WatchdogLimit = 200000;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [47:0] mass;
    logic        last;
  } body_t;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [47:0] mass;
    logic [6:0]  count;
    logic        last;
  } survivor_t;

  // Mirrors the body store and produces the survivor list for each closed set.
  class merge_scoreboard;
    body_t       store [BodyLimit];
    bit          alive [BodyLimit];
    int unsigned loaded;
    logic [31:0] merge_dist;
    survivor_t   survivors_due [$];
    int unsigned errors;

    function void clear();
      loaded = 0;
      merge_dist = ncm_pkg::MergeDistReset;
      foreach (alive[i]) alive[i] = 1'b0;
    endfunction

    function bit close_pair(int unsigned j, int unsigned k);
      logic [65:0] dist_sq;
      logic [63:0] limit_sq;
      logic [31:0] d;
      dist_sq = '0;
      for (int c = 0; c < 3; c++) begin
        d = (store[j].pos[c] > store[k].pos[c]) ? store[j].pos[c] - store[k].pos[c]
                                                : store[k].pos[c] - store[j].pos[c];
        dist_sq += 66'({32'b0, d} * {32'b0, d});
      end
      limit_sq = {32'b0, merge_dist} * {32'b0, merge_dist};
      return dist_sq < 66'(limit_sq);
    endfunction

    function logic [31:0] sat_vel(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] s;
      s = $signed({a[31], a}) + $signed({b[31], b});
      if (s > 33'sd2147483647) return 32'h7FFF_FFFF;
      if (s < -33'sd2147483648) return 32'h8000_0000;
      return s[31:0];
    endfunction

    // Called for every body transfer accepted on the input channel.
    function void note_body(body_t b);
      logic [48:0] m;
      int unsigned total;
      int unsigned sent;
      survivor_t r;
      if (loaded < BodyLimit) begin
        store[loaded] = b;
        alive[loaded] = 1'b1;
        loaded++;
      end
      if (!b.last) return;
      // Merge later bodies into the earliest live one they touch.
      for (int unsigned j = 0; j < loaded; j++) begin
        if (!alive[j]) continue;
        for (int unsigned k = j + 1; k < loaded; k++) begin
          if (!alive[k] || !close_pair(j, k)) continue;
          m = {1'b0, store[j].mass} + {1'b0, store[k].mass};
          store[j].mass = m[48] ? ncm_pkg::MassMax : m[47:0];
          for (int c = 0; c < 3; c++) store[j].vel[c] = sat_vel(store[j].vel[c], store[k].vel[c]);
          alive[k] = 1'b0;
        end
      end
      total = 0;
      for (int unsigned j = 0; j < loaded; j++) if (alive[j]) total++;
      sent = 0;
      for (int unsigned j = 0; j < loaded; j++) begin
        if (!alive[j]) continue;
        sent++;
        r.index = 6'(j);
        r.pos = store[j].pos;
        r.vel = store[j].vel;
        r.mass = store[j].mass;
        r.count = 7'(total);
        r.last = (sent == total);
        survivors_due.push_back(r);
      end
      loaded = 0;
      foreach (alive[i]) alive[i] = 1'b0;
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // Called for every result transfer accepted on the output channel.
    function void check_survivor(survivor_t r);
      survivor_t e;
      if (survivors_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual index %0d", $time, r.index);
        return;
      end
      e = survivors_due.pop_front();
      field("body_index", e.index, r.index);
      for (int c = 0; c < 3; c++) begin
        field($sformatf("out_pos[%0d]", c), e.pos[c], r.pos[c]);
        field($sformatf("out_vel[%0d]", c), e.vel[c], r.vel[c]);
      end
      field("out_mass", e.mass, r.mass);
      field("survivor_count", e.count, r.count);
      field("last_result", e.last, r.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [47:0] mass_i = '0;
  logic last_object_i = 1'b0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [5:0] body_index_o;
  logic [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [31:0] out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic [47:0] out_mass_o;
  logic [6:0] survivor_count_o;
  logic last_result_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nbody_collision_merge_unit dut (.*);

  merge_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_long = 1'b0;
  int unsigned quiet_cycles = 0;

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[nbody_collision_merge_unit] ERROR");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  initial begin : receiver
    int unsigned n;
    survivor_t r;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = hold_long ? 3000 : (calm ? 0 : $urandom_range(0, 14));
      hold_long = 1'b0;
      if (n > 0) begin
        stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!valid_o);
      r.index = body_index_o;
      r.pos = '{out_pos_x_o, out_pos_y_o, out_pos_z_o};
      r.vel = '{out_vel_x_o, out_vel_y_o, out_vel_z_o};
      r.mass = out_mass_o;
      r.count = survivor_count_o;
      r.last = last_result_o;
      sb.check_survivor(r);
    end
  end

  // One body transfer, with a random gap before it.
  task automatic send_body(body_t b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    {pos_x_i, pos_y_i, pos_z_i} <= {b.pos[0], b.pos[1], b.pos[2]};
    {vel_x_i, vel_y_i, vel_z_i} <= {b.vel[0], b.vel[1], b.vel[2]};
    mass_i <= b.mass;
    last_object_i <= b.last;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    sb.note_body(b);
    @(negedge clk_i);
  endtask

  // Register write while the block is idle.
  task automatic write_merge_dist(logic [31:0] value);
    wait (sb.survivors_due.size() == 0);
    valid_i <= 1'b0;
    do @(negedge clk_i); while (stall_o);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'(4 * ncm_pkg::RegMergeDist);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.merge_dist = value;
  endtask

  function automatic body_t make_body(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [31:0] v, logic [47:0] m, logic last);
    body_t b;
    b.pos = '{x, y, z};
    b.vel = '{v, v, v};
    b.mass = m;
    b.last = last;
    return b;
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Random set clustered around one point so that merges are frequent.
  task automatic send_cluster(int unsigned size);
    logic [31:0] base [3];
    logic [31:0] spread;
    body_t b;
    foreach (base[c]) base[c] = $urandom;
    spread = (sb.merge_dist == 0) ? 32'd4 : sb.merge_dist;
    for (int unsigned i = 0; i < size; i++) begin
      foreach (b.pos[c]) b.pos[c] = base[c] + $urandom_range(0, spread);
      foreach (b.vel[c]) b.vel[c] = rand_vel();
      b.mass = ($urandom_range(0, 3) == 0) ? ncm_pkg::MassMax - $urandom_range(0, 7)
                                            : 48'({$urandom, $urandom});
      b.last = (i == size - 1);
      send_body(b);
    end
  endtask

  initial begin : stimulus
    logic [31:0] dists [4];
    sb.clear();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: exact distance, saturation at both ends, a lone body.
    send_body(make_body(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, ncm_pkg::MassMax, 1'b0));
    send_body(make_body(32'h0, 32'h0, 32'h0001_0000, 32'h1234_5678, 48'd5, 1'b0));
    send_body(make_body(32'h0, 32'h0, 32'h0000_FFFF, 32'h7FFF_FFFF, 48'd9, 1'b0));
    send_body(make_body('1, '1, '1, 32'h8000_0000, 48'd0, 1'b0));
    send_body(make_body('1, '1, 32'hFFFF_FFFE, 32'h8000_0000, 48'd1, 1'b1));
    send_body(make_body(32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0F0F_F0F0, 32'h0, 48'd7, 1'b1));
    // A zero distance merges nothing, not even coincident bodies.
    write_merge_dist(32'h0);
    send_body(make_body(32'h10, 32'h10, 32'h10, 32'h1, 48'd1, 1'b0));
    send_body(make_body(32'h10, 32'h10, 32'h10, 32'h1, 48'd1, 1'b1));
    // The widest distance, with opposite corners whose squared sum overflows.
    write_merge_dist('1);
    send_body(make_body(32'h0, 32'h0, 32'h0, 32'h5, 48'd2, 1'b0));
    send_body(make_body('1, '1, '1, 32'h6, 48'd3, 1'b0));
    send_body(make_body(32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 48'd4, 1'b1));

    // Random sets over several distances, one of them overfilling the store.
    dists = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF, $urandom_range(0, 32'h0008_0000)};
    foreach (dists[p]) begin
      write_merge_dist(dists[p]);
      for (int s = 0; s < 3; s++) begin
        calm = ($urandom_range(0, 3) == 0);
        if (p == 1 && s == 0) hold_long = 1'b1;
        send_cluster((p == 3 && s == 1) ? 66 : $urandom_range(1, 6));
      end
    end
    calm = 1'b0;
    valid_i <= 1'b0;

    wait (sb.survivors_due.size() == 0);
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("[nbody_collision_merge_unit] OK");
    end else begin
      $display("[nbody_collision_merge_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ncm_pkg.sv
rtl/ncm_sq_unit.sv
rtl/nbody_collision_merge_unit.sv
rtl/ncm_checker.sv
bench/tb_nbody_collision_merge_unit.sv
